### src/mrwt_pkg.sv
// ----------------------------------------------------------------------------
// mrwt_pkg
// Shared types and constants for the Miller-Rabin witness test block.
// ----------------------------------------------------------------------------
package mrwt_pkg;

   localparam int WIT_W  = 32;
   localparam int DCNT_W = 5;

   typedef enum logic [1:0] {
      VERDICT_SMALL_PRIME = 2'd0,
      VERDICT_REJECT      = 2'd1,
      VERDICT_COMPOSITE   = 2'd2,
      VERDICT_PASS        = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      MSEL_RES_BASE  = 2'd0,
      MSEL_BASE_BASE = 2'd1,
      MSEL_RES_RES   = 2'd2
   } msel_type;

   typedef enum logic {
      MDEST_RES  = 1'b0,
      MDEST_BASE = 1'b1
   } mdest_type;

   typedef struct packed {
      logic        load;
      logic        red_step;
      logic        fac_step;
      logic        pow_init;
      logic        mul_start;
      msel_type    mul_sel;
      logic        mul_step;
      mdest_type   mul_dest;
      logic        e_shift;
      logic        j_dec;
      logic        finish;
      verdict_type verdict;
   } cmd_type;

   typedef struct packed {
      logic n_le1;
      logic n_le3;
      logic n_even;
      logic red_last;
      logic r_even;
      logic e_zero;
      logic e_lsb;
      logic mul_last;
      logic x_one;
      logic x_nm1;
      logic j_zero;
      logic out_free;
   } status_type;

endpackage

### src/mrwt_dp.sv
// ----------------------------------------------------------------------------
// mrwt_dp
// Datapath: witness reduction, n-1 factoring, serial modular multiplier,
// sticky composite flag and result register.
// ----------------------------------------------------------------------------
module mrwt_dp #(
   parameter int MW = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [mrwt_pkg::WIT_W-1:0] req_candidate,
   input  logic [mrwt_pkg::WIT_W-1:0] req_witness,
   input  logic                       req_last_witness,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_probable_prime,
   output logic [1:0]                 rsp_verdict,
   input  mrwt_pkg::cmd_type          cmd,
   output mrwt_pkg::status_type       st
);

   localparam int CW = $clog2(MW);

   logic [MW-1:0]                 n_ff, rem_ff, r_ff, e_ff, res_ff, base_ff;
   logic [MW-1:0]                 ma_ff, mb_ff, acc_ff;
   logic [mrwt_pkg::WIT_W-1:0]    w_ff;
   logic [mrwt_pkg::DCNT_W-1:0]   dcnt_ff;
   logic [CW-1:0]                 s_ff, j_ff, mcnt_ff;
   logic                          last_ff, seen_ff;
   logic                          rsp_valid_ff, pp_ff;
   logic [1:0]                    verdict_ff;

   logic [MW:0]   red_t;
   logic [MW-1:0] rem_in, dbl, acc_in, nm1;
   logic          fail, sticky;

   function automatic logic [MW-1:0] add_mod(input logic [MW-1:0] a,
                                             input logic [MW-1:0] b,
                                             input logic [MW-1:0] m);
      logic [MW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, m}) sum = sum - {1'b0, m};
      return sum[MW-1:0];
   endfunction

   assign nm1    = n_ff - {{(MW-1){1'b0}}, 1'b1};
   assign red_t  = {rem_ff, w_ff[mrwt_pkg::WIT_W-1]};
   assign rem_in = (red_t >= {1'b0, n_ff}) ? MW'(red_t - {1'b0, n_ff}) : red_t[MW-1:0];
   assign dbl    = add_mod(acc_ff, acc_ff, n_ff);
   assign acc_in = mb_ff[MW-1] ? add_mod(dbl, ma_ff, n_ff) : dbl;

   assign fail   = (cmd.verdict == mrwt_pkg::VERDICT_REJECT) ||
                   (cmd.verdict == mrwt_pkg::VERDICT_COMPOSITE);
   assign sticky = seen_ff | fail;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff    <= req_candidate[MW-1:0];
         r_ff    <= req_candidate[MW-1:0] - {{(MW-1){1'b0}}, 1'b1};
         w_ff    <= req_witness;
         last_ff <= req_last_witness;
         rem_ff  <= '0;
         dcnt_ff <= '0;
         s_ff    <= '0;
      end
      if (cmd.red_step) begin
         rem_ff  <= rem_in;
         w_ff    <= {w_ff[mrwt_pkg::WIT_W-2:0], 1'b0};
         dcnt_ff <= dcnt_ff + 1'b1;
      end
      if (cmd.fac_step) begin
         r_ff <= {1'b0, r_ff[MW-1:1]};
         s_ff <= s_ff + 1'b1;
      end
      if (cmd.pow_init) begin
         res_ff  <= {{(MW-1){1'b0}}, 1'b1};
         base_ff <= rem_ff;
         e_ff    <= r_ff;
         j_ff    <= s_ff - 1'b1;
      end
      if (cmd.mul_step) begin
         acc_ff  <= acc_in;
         mb_ff   <= {mb_ff[MW-2:0], 1'b0};
         mcnt_ff <= mcnt_ff + 1'b1;
         if (st.mul_last) begin
            if (cmd.mul_dest == mrwt_pkg::MDEST_RES) res_ff <= acc_in;
            else                                      base_ff <= acc_in;
         end
      end
      if (cmd.mul_start) begin
         acc_ff  <= '0;
         mcnt_ff <= '0;
         case (cmd.mul_sel)
            mrwt_pkg::MSEL_RES_BASE: begin
               ma_ff <= res_ff;
               mb_ff <= base_ff;
            end
            mrwt_pkg::MSEL_BASE_BASE: begin
               ma_ff <= base_ff;
               mb_ff <= base_ff;
            end
            default: begin
               ma_ff <= res_ff;
               mb_ff <= res_ff;
            end
         endcase
      end
      if (cmd.e_shift) e_ff <= {1'b0, e_ff[MW-1:1]};
      if (cmd.j_dec)   j_ff <= j_ff - 1'b1;
      if (cmd.finish && st.out_free) begin
         pp_ff      <= ~sticky;
         verdict_ff <= cmd.verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish && st.out_free) begin
            seen_ff      <= last_ff ? 1'b0 : sticky;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign st.n_le1    = (n_ff[MW-1:1] == '0);
   assign st.n_le3    = (n_ff[MW-1:2] == '0);
   assign st.n_even   = ~n_ff[0];
   assign st.red_last = &dcnt_ff;
   assign st.r_even   = ~r_ff[0];
   assign st.e_zero   = (e_ff == '0);
   assign st.e_lsb    = e_ff[0];
   assign st.mul_last = (mcnt_ff == CW'(MW-1));
   assign st.x_one    = (res_ff == {{(MW-1){1'b0}}, 1'b1});
   assign st.x_nm1    = (res_ff == nm1);
   assign st.j_zero   = (j_ff == '0);
   assign st.out_free = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_probable_prime = pp_ff;
   assign rsp_verdict        = verdict_ff;

endmodule

### src/mrwt_ctrl.sv
// ----------------------------------------------------------------------------
// mrwt_ctrl
// Controller: sequences classification, reduction, exponentiation and the
// squaring loop, then hands the verdict to the result register.
// ----------------------------------------------------------------------------
module mrwt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output mrwt_pkg::cmd_type    cmd,
   input  mrwt_pkg::status_type st
);

   typedef enum logic [10:0] {
      S_IDLE     = 11'b00000000001,
      S_CLASSIFY = 11'b00000000010,
      S_REDUCE   = 11'b00000000100,
      S_FACTOR   = 11'b00000001000,
      S_POW      = 11'b00000010000,
      S_MUL_RB   = 11'b00000100000,
      S_MUL_BB   = 11'b00001000000,
      S_CHECK    = 11'b00010000000,
      S_MUL_XX   = 11'b00100000000,
      S_SQ_CHECK = 11'b01000000000,
      S_FINISH   = 11'b10000000000
   } state_type;

   state_type             state_ff, state_in;
   mrwt_pkg::verdict_type verdict_ff, verdict_in;

   always_comb begin
      state_in    = state_ff;
      verdict_in  = verdict_ff;
      cmd         = '0;
      cmd.verdict = verdict_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            if (st.n_le1) begin
               verdict_in = mrwt_pkg::VERDICT_REJECT;
               state_in   = S_FINISH;
            end else if (st.n_le3) begin
               verdict_in = mrwt_pkg::VERDICT_SMALL_PRIME;
               state_in   = S_FINISH;
            end else if (st.n_even) begin
               verdict_in = mrwt_pkg::VERDICT_REJECT;
               state_in   = S_FINISH;
            end else begin
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            cmd.red_step = 1'b1;
            if (st.red_last) state_in = S_FACTOR;
         end
         S_FACTOR: begin
            if (st.r_even) begin
               cmd.fac_step = 1'b1;
            end else begin
               cmd.pow_init = 1'b1;
               state_in     = S_POW;
            end
         end
         S_POW: begin
            if (st.e_zero) begin
               state_in = S_CHECK;
            end else if (st.e_lsb) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = mrwt_pkg::MSEL_RES_BASE;
               state_in      = S_MUL_RB;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = mrwt_pkg::MSEL_BASE_BASE;
               state_in      = S_MUL_BB;
            end
         end
         S_MUL_RB: begin
            cmd.mul_step = 1'b1;
            cmd.mul_dest = mrwt_pkg::MDEST_RES;
            if (st.mul_last) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = mrwt_pkg::MSEL_BASE_BASE;
               state_in      = S_MUL_BB;
            end
         end
         S_MUL_BB: begin
            cmd.mul_step = 1'b1;
            cmd.mul_dest = mrwt_pkg::MDEST_BASE;
            if (st.mul_last) begin
               cmd.e_shift = 1'b1;
               state_in    = S_POW;
            end
         end
         S_CHECK: begin
            if (st.x_one || st.x_nm1) begin
               verdict_in = mrwt_pkg::VERDICT_PASS;
               state_in   = S_FINISH;
            end else if (st.j_zero) begin
               verdict_in = mrwt_pkg::VERDICT_COMPOSITE;
               state_in   = S_FINISH;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = mrwt_pkg::MSEL_RES_RES;
               state_in      = S_MUL_XX;
            end
         end
         S_MUL_XX: begin
            cmd.mul_step = 1'b1;
            cmd.mul_dest = mrwt_pkg::MDEST_RES;
            if (st.mul_last) begin
               cmd.j_dec = 1'b1;
               state_in  = S_SQ_CHECK;
            end
         end
         S_SQ_CHECK: begin
            if (st.x_nm1) begin
               verdict_in = mrwt_pkg::VERDICT_PASS;
               state_in   = S_FINISH;
            end else if (st.j_zero) begin
               verdict_in = mrwt_pkg::VERDICT_COMPOSITE;
               state_in   = S_FINISH;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = mrwt_pkg::MSEL_RES_RES;
               state_in      = S_MUL_XX;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            if (st.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
      verdict_ff <= verdict_in;
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

### src/miller_rabin_witness_test.sv
// ----------------------------------------------------------------------------
// miller_rabin_witness_test
// One Miller-Rabin round per request beat; sticky composite flag per group.
// ----------------------------------------------------------------------------
// Request channel (req_*): candidate, witness and last_witness mark. A beat
// is taken when req_valid is high and req_stall low; req_stall is high while
// an item is in work, so one item is handled at a time.
// Response channel (rsp_*): one beat per request with probable_prime and a
// two-bit verdict. The response sits in an output register; the next request
// is taken while it waits, and that item finishes only once the register is
// free.
// Steps per item: small, even and tiny candidates go through idle, classify
// and finish. Others go through idle, classify, witness reduction (one bit a
// cycle), the trailing zeros of n-1 and setup; per exponent bit of r a product
// and a squaring if set, a squaring alone if clear; the end of the exponent and
// the check; a squaring and a check per extra squaring; finish. MW is
// min(NUM_BITS, 32); each modular product uses the serial double-and-add multiplier.
// Reset clears the controller, the response valid and the sticky flag.
// A stalled response holds its values until taken.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test #(
   parameter int NUM_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_candidate,
   input  logic [31:0] req_witness,
   input  logic        req_last_witness,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_probable_prime,
   output logic [1:0]  rsp_verdict
);

   localparam int MW = (NUM_BITS < 32) ? NUM_BITS : 32;

   mrwt_pkg::cmd_type    cmd;
   mrwt_pkg::status_type st;

   mrwt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .st        (st)
   );

   mrwt_dp #(.MW(MW)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_candidate      (req_candidate),
      .req_witness        (req_witness),
      .req_last_witness   (req_last_witness),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_probable_prime (rsp_probable_prime),
      .rsp_verdict        (rsp_verdict),
      .cmd                (cmd),
      .st                 (st)
   );

endmodule
